// File: rtl/core/bcd_pkg.sv
// Bumper contact detector package: shared widths, config indices and the
// per-foot result type. No dependencies.
`timescale 1ns / 1ps

package bcd_pkg;

  // Sliding window length in frames (1 to 64)
  localparam int unsigned WINDOW = 8;

  localparam int unsigned SumW   = $clog2(WINDOW + 1);
  localparam int unsigned ThrW   = 4;
  localparam int unsigned CmpW   = (SumW > ThrW) ? SumW : ThrW;
  localparam int unsigned CntW   = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned DataW  = 16;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // Configuration register indices
  typedef enum logic [IdxW-1:0] {
    CfgThreshold   = 8'd0,
    CfgMalfLimit   = 8'd1,
    CfgLeftDefect  = 8'd2,
    CfgRightDefect = 8'd3
  } cfg_idx_e;

  // Reset values of the configuration registers
  localparam logic [ThrW-1:0] ThresholdRst = 4'd2;
  localparam logic [CntW-1:0] MalfLimitRst = 16'd200;

  // One foot's part of a result item
  typedef struct packed {
    logic             contact;
    logic [CntW-1:0]  duration;
    logic [TimeW-1:0] last_time;
  } foot_res_t;

endpackage

// File: rtl/core/bcd_bumper.sv
// Bumper press counter with malfunction cut-off and defect masking.
// Depends on bcd_pkg.
`timescale 1ns / 1ps

module bcd_bumper (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    advance_i,
  input  logic                    defect_i,
  input  logic                    pressed_i,
  input  logic [bcd_pkg::CntW-1:0] limit_i,
  output logic                    touch_o
);
  import bcd_pkg::*;

  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;

  // Count consecutive pressed frames, saturating; clear on release
  always_comb begin
    if (!pressed_i) begin
      count_d = '0;
    end else if (count_q == CntMax) begin
      count_d = count_q;
    end else begin
      count_d = count_q + CntW'(1);
    end
  end

  assign touch_o = !defect_i && pressed_i && (count_d < limit_i);

  // Freeze the counter while the foot is marked defective
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (advance_i && !defect_i) begin
      count_q <= count_d;
    end
  end

endmodule

// File: rtl/core/bcd_foot.sv
// Per-foot contact window, window sum, run length and last contact time.
// Depends on bcd_pkg.
`timescale 1ns / 1ps

module bcd_foot (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     advance_i,
  input  logic                     touch_i,
  input  logic                     gates_i,
  input  logic [bcd_pkg::ThrW-1:0]  threshold_i,
  input  logic [bcd_pkg::TimeW-1:0] now_i,
  output bcd_pkg::foot_res_t       res_o
);
  import bcd_pkg::*;

  logic [WINDOW-1:0] win_q, win_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [CntW-1:0]   run_q, run_d;
  logic [TimeW-1:0]  last_q, last_d;
  logic              contact;

  // Shift the touch bit in and keep the population count in step
  assign win_d = WINDOW'({win_q, touch_i});
  assign sum_d = sum_q - SumW'(win_q[WINDOW-1]) + SumW'(touch_i);

  // Run length of consecutive touching frames, saturating
  always_comb begin
    if (!touch_i) begin
      run_d = '0;
    end else if (run_q == CntMax) begin
      run_d = run_q;
    end else begin
      run_d = run_q + CntW'(1);
    end
  end

  assign contact = gates_i && (CmpW'(sum_d) > CmpW'(threshold_i));
  assign last_d  = contact ? now_i : last_q;

  assign res_o.contact   = contact;
  assign res_o.duration  = contact ? run_d : '0;
  assign res_o.last_time = last_d;

  // Advance the foot state once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      sum_q  <= '0;
      run_q  <= '0;
      last_q <= '0;
    end else if (advance_i) begin
      win_q  <= win_d;
      sum_q  <= sum_d;
      run_q  <= run_d;
      last_q <= last_d;
    end
  end

endmodule

// File: rtl/core/bumper_contact_detector_unit.sv
// Bumper contact detector top level: input register, four bumper counters,
// two foot windows and a result register. Depends on bcd_pkg, bcd_bumper, bcd_foot.
// Flow: an accepted item is held in the input register and then moves on into the result
// register, from which it is taken; a stalled result register holds it back.
// Throughput: one item per cycle; both registers advance together when the
// result register is empty or being taken. Reset (async, active low) clears
// all counters, windows and valid flags and loads the register defaults.
`timescale 1ns / 1ps

module bumper_contact_detector_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration write channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [bcd_pkg::IdxW-1:0]  cfg_index_i,
  input  logic [bcd_pkg::DataW-1:0] cfg_data_i,
  // Input channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      left_foot_left_i,
  input  logic                      left_foot_right_i,
  input  logic                      right_foot_left_i,
  input  logic                      right_foot_right_i,
  input  logic                      motion_ok_i,
  input  logic                      phase_ok_i,
  input  logic                      upright_i,
  input  logic [bcd_pkg::TimeW-1:0] frame_time_i,
  // Output channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      contact_left_o,
  output logic                      contact_right_o,
  output logic [bcd_pkg::CntW-1:0]  duration_left_o,
  output logic [bcd_pkg::CntW-1:0]  duration_right_o,
  output logic [bcd_pkg::TimeW-1:0] last_time_left_o,
  output logic [bcd_pkg::TimeW-1:0] last_time_right_o
);
  import bcd_pkg::*;

  logic [ThrW-1:0]  threshold_q;
  logic [CntW-1:0]  malf_limit_q;
  logic             left_defect_q;
  logic             right_defect_q;

  logic             s1_valid_q;
  logic [3:0]       pressed_q;
  logic             gates_q;
  logic [TimeW-1:0] time_q;

  logic             s1_move;
  logic             in_accept;
  logic [3:0]       touch;
  foot_res_t        left_res, right_res;
  foot_res_t        left_q, right_q;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q    <= ThresholdRst;
      malf_limit_q   <= MalfLimitRst;
      left_defect_q  <= 1'b0;
      right_defect_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgThreshold:   threshold_q    <= cfg_data_i[ThrW-1:0];
        CfgMalfLimit:   malf_limit_q   <= cfg_data_i[CntW-1:0];
        CfgLeftDefect:  left_defect_q  <= cfg_data_i[0];
        CfgRightDefect: right_defect_q <= cfg_data_i[0];
        default:        ;
      endcase
    end
  end

  // Pipeline flow: advance when the result slot is free or being taken
  assign s1_move    = s1_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pressed_q <= {right_foot_right_i, right_foot_left_i,
                    left_foot_right_i, left_foot_left_i};
      gates_q   <= motion_ok_i && phase_ok_i && upright_i;
      time_q    <= frame_time_i;
    end
  end

  // Bumper counters
  for (genvar b = 0; b < 4; b++) begin : g_bumper
    bcd_bumper u_bumper (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (s1_move),
      .defect_i  ((b < 2) ? left_defect_q : right_defect_q),
      .pressed_i (pressed_q[b]),
      .limit_i   (malf_limit_q),
      .touch_o   (touch[b])
    );
  end

  // Foot windows
  bcd_foot u_foot_left (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (s1_move),
    .touch_i     (touch[0] || touch[1]),
    .gates_i     (gates_q),
    .threshold_i (threshold_q),
    .now_i       (time_q),
    .res_o       (left_res)
  );

  bcd_foot u_foot_right (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (s1_move),
    .touch_i     (touch[2] || touch[3]),
    .gates_i     (gates_q),
    .threshold_i (threshold_q),
    .now_i       (time_q),
    .res_o       (right_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (!out_valid_o || !out_stall_i) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      left_q  <= left_res;
      right_q <= right_res;
    end
  end

  assign contact_left_o    = left_q.contact;
  assign contact_right_o   = right_q.contact;
  assign duration_left_o   = left_q.duration;
  assign duration_right_o  = right_q.duration;
  assign last_time_left_o  = left_q.last_time;
  assign last_time_right_o = right_q.last_time;

`ifndef NO_ASSERTIONS
  // An empty input register never holds off the source
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with empty input register");

  // A pending item reaches an empty result slot on the next edge
  a_fill_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_valid_o |=> out_valid_o)
    else $error("item lost between input and result register");

  // No contact means no duration
  a_dur_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !contact_left_o |-> duration_left_o == '0)
    else $error("left duration without contact");

  a_dur_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !contact_right_o |-> duration_right_o == '0)
    else $error("right duration without contact");
`endif

endmodule

// File: bench/bumper_contact_detector_unit_tb.sv
// Self-checking testbench for bumper_contact_detector_unit: drives sensor frames and
// register writes, predicts every result item in-bench and compares field by field.
// Depends on bcd_pkg and the bumper_contact_detector_unit RTL.
`timescale 1ns / 1ps

module bumper_contact_detector_unit_tb;
  import bcd_pkg::*;

  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned ReportMax    = 10;
  localparam int unsigned DrainCycles  = 4;
  localparam int unsigned RandomPhases = 7;
  localparam int unsigned PhaseItems   = 150;

  // Indexes with no register behind them
  localparam logic [IdxW-1:0] CfgIdxUnused = 8'd4;
  localparam logic [IdxW-1:0] CfgIdxTop    = 8'hFF;

  // Bumper and gate patterns, bit order as in frame_t
  localparam logic [3:0] NonePressed = 4'b0000;
  localparam logic [3:0] AllPressed  = 4'b1111;
  localparam logic [2:0] GatesOpen   = 3'b111;

  typedef struct packed {
    logic             lfl, lfr, rfl, rfr;
    logic             motion_ok, phase_ok, upright;
    logic [TimeW-1:0] stamp;
  } frame_t;

  typedef struct packed {
    foot_res_t left;
    foot_res_t right;
  } contact_res_t;

  logic              clk_i  = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [IdxW-1:0]   cfg_index_i = '0;
  logic [DataW-1:0]  cfg_data_i  = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic              left_foot_left_i   = 1'b0;
  logic              left_foot_right_i  = 1'b0;
  logic              right_foot_left_i  = 1'b0;
  logic              right_foot_right_i = 1'b0;
  logic              motion_ok_i = 1'b0;
  logic              phase_ok_i  = 1'b0;
  logic              upright_i   = 1'b0;
  logic [TimeW-1:0]  frame_time_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              contact_left_o, contact_right_o;
  logic [CntW-1:0]   duration_left_o, duration_right_o;
  logic [TimeW-1:0]  last_time_left_o, last_time_right_o;

  // Register copies and detector state, all at their reset values
  logic [ThrW-1:0]   threshold_q    = ThresholdRst;
  logic [CntW-1:0]   malf_limit_q   = MalfLimitRst;
  logic              left_defect_q  = 1'b0;
  logic              right_defect_q = 1'b0;
  logic [CntW-1:0]   press_cnt   [4] = '{default: '0};
  logic [CntW-1:0]   run_cnt     [2] = '{default: '0};
  logic [WINDOW-1:0] window_bits [2] = '{default: '0};
  int unsigned       window_sum  [2] = '{default: 0};
  logic [TimeW-1:0]  last_seen   [2] = '{default: '0};

  contact_res_t      pending_contacts [$];
  int unsigned       mismatches  = 0;
  int unsigned       cycle_count = 0;
  bit                idle_on     = 1'b1;
  logic [3:0]        held_bumpers = '0;
  logic [TimeW-1:0]  clock_ms     = '0;

  bumper_contact_detector_unit dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stall the result side now and then
  always @(posedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < 10);
  end

  // Advance one press counter; report whether the bumper counts as touching
  function automatic logic press_touch(input int unsigned idx, input logic pressed);
    if (!pressed) begin
      press_cnt[idx] = '0;
    end else if (press_cnt[idx] != CntMax) begin
      press_cnt[idx] = press_cnt[idx] + 1'b1;
    end
    return pressed && (press_cnt[idx] < malf_limit_q);
  endfunction

  // Shift one foot's touch bit into its window and update its run length
  function automatic void foot_shift(input int unsigned foot, input logic touch);
    logic leaving;
    leaving = window_bits[foot][WINDOW-1];
    window_bits[foot] = (window_bits[foot] << 1) | WINDOW'(touch);
    window_sum[foot] = window_sum[foot] - leaving + touch;
    if (!touch) begin
      run_cnt[foot] = '0;
    end else if (run_cnt[foot] != CntMax) begin
      run_cnt[foot] = run_cnt[foot] + 1'b1;
    end
  endfunction

  // Work out the result item that one frame produces
  function automatic contact_res_t compute_contact(input frame_t f);
    contact_res_t r;
    foot_res_t    res [2];
    logic [3:0]   touch;
    logic         gates;
    touch = '0;
    gates = f.motion_ok & f.phase_ok & f.upright;
    // A defective foot leaves its press counters frozen
    if (!left_defect_q) begin
      touch[0] = press_touch(0, f.lfl);
      touch[1] = press_touch(1, f.lfr);
    end
    if (!right_defect_q) begin
      touch[2] = press_touch(2, f.rfl);
      touch[3] = press_touch(3, f.rfr);
    end
    foot_shift(0, touch[0] | touch[1]);
    foot_shift(1, touch[2] | touch[3]);
    for (int unsigned foot = 0; foot < 2; foot++) begin
      res[foot].contact  = gates && (window_sum[foot] > threshold_q);
      res[foot].duration = res[foot].contact ? run_cnt[foot] : '0;
      if (res[foot].contact) begin
        last_seen[foot] = f.stamp;
      end
      res[foot].last_time = last_seen[foot];
    end
    r.left  = res[0];
    r.right = res[1];
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [TimeW-1:0] want,
                               input logic [TimeW-1:0] got);
    mismatches++;
    if (mismatches <= ReportMax) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  task automatic check_foot(input string side, input foot_res_t want, input foot_res_t got);
    if (got.contact !== want.contact) begin
      note_mismatch({side, " contact"}, TimeW'(want.contact), TimeW'(got.contact));
    end
    if (got.duration !== want.duration) begin
      note_mismatch({side, " duration"}, TimeW'(want.duration), TimeW'(got.duration));
    end
    if (got.last_time !== want.last_time) begin
      note_mismatch({side, " last time"}, want.last_time, got.last_time);
    end
  endtask

  // Check taken results, predict accepted frames, mirror register writes
  always @(posedge clk_i) begin
    contact_res_t got, want;
    frame_t       seen;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.left  = {contact_left_o, duration_left_o, last_time_left_o};
      got.right = {contact_right_o, duration_right_o, last_time_right_o};
      if (pending_contacts.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax) begin
          $display("result item with nothing expected: %p", got);
        end
      end else begin
        want = pending_contacts.pop_front();
        check_foot("left", want.left, got.left);
        check_foot("right", want.right, got.right);
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      seen = {left_foot_left_i, left_foot_right_i, right_foot_left_i, right_foot_right_i,
              motion_ok_i, phase_ok_i, upright_i, frame_time_i};
      pending_contacts.push_back(compute_contact(seen));
    end
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgThreshold:   threshold_q    = cfg_data_i[ThrW-1:0];
        CfgMalfLimit:   malf_limit_q   = cfg_data_i[CntW-1:0];
        CfgLeftDefect:  left_defect_q  = cfg_data_i[0];
        CfgRightDefect: right_defect_q = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  function automatic frame_t make_frame(input logic [3:0] bumpers, input logic [2:0] gates,
                                        input logic [TimeW-1:0] stamp);
    return {bumpers, gates, stamp};
  endfunction

  // Offer one item, with an occasional gap first, and hold it until taken
  task automatic send_frame(input frame_t f);
    int unsigned gap;
    gap = (idle_on && $urandom_range(99) < 5) ? $urandom_range(3, 1) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    {left_foot_left_i, left_foot_right_i, right_foot_left_i, right_foot_right_i,
     motion_ok_i, phase_ok_i, upright_i, frame_time_i} <= f;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and wait until every expected item has come out
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_contacts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [DataW-1:0] data);
    settle();
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Default registers: full and empty fields, each gate closed, each bumper alone
  task automatic test_field_extremes();
    send_frame(make_frame(AllPressed, GatesOpen, '0));
    repeat (3) send_frame(make_frame(AllPressed, GatesOpen, '1));
    send_frame(make_frame(AllPressed, 3'b011, $urandom));
    send_frame(make_frame(AllPressed, 3'b101, $urandom));
    send_frame(make_frame(AllPressed, 3'b110, $urandom));
    send_frame(make_frame(NonePressed, GatesOpen, $urandom));
    for (int unsigned b = 0; b < 4; b++) begin
      send_frame(make_frame(4'b1000 >> b, GatesOpen, $urandom));
    end
  endtask

  // Unused indexes are dropped and wide data is cut to the register width
  task automatic test_register_writes();
    write_reg(CfgIdxUnused, 16'hFFFF);
    write_reg(CfgIdxTop, 16'h0000);
    write_reg(CfgThreshold, 16'hFFF0);
    write_reg(CfgMalfLimit, 16'd1);
    repeat (2) send_frame(make_frame(AllPressed, GatesOpen, $urandom));
    write_reg(CfgMalfLimit, 16'd0);
    send_frame(make_frame(AllPressed, GatesOpen, $urandom));
    write_reg(CfgMalfLimit, 16'd3);
    send_frame(make_frame(NonePressed, GatesOpen, $urandom));
    repeat (3) send_frame(make_frame(AllPressed, GatesOpen, $urandom));
  endtask

  // Masked feet freeze their press counters and resume where they stopped
  task automatic test_defect_masking();
    write_reg(CfgThreshold, 16'd0);
    write_reg(CfgMalfLimit, 16'd4);
    send_frame(make_frame(NonePressed, GatesOpen, $urandom));
    repeat (2) send_frame(make_frame(AllPressed, GatesOpen, $urandom));
    write_reg(CfgLeftDefect, 16'hFFFF);
    write_reg(CfgRightDefect, 16'h0003);
    repeat (2) send_frame(make_frame(AllPressed, GatesOpen, $urandom));
    write_reg(CfgLeftDefect, 16'hFFFE);
    write_reg(CfgRightDefect, 16'd0);
    repeat (3) send_frame(make_frame(AllPressed, GatesOpen, $urandom));
  endtask

  // A threshold at the window length can never be exceeded
  task automatic test_threshold_above_window();
    write_reg(CfgThreshold, DataW'(WINDOW));
    write_reg(CfgMalfLimit, 16'hFFFF);
    repeat (WINDOW + 1) send_frame(make_frame(AllPressed, GatesOpen, $urandom));
  endtask

  // Random phases: fresh registers, then frames with sticky bumper presses
  task automatic test_random_frames();
    logic [ThrW-1:0] thr_pick [RandomPhases];
    logic [CntW-1:0] malf_pick [RandomPhases];
    int unsigned     churn;
    logic [2:0]      gates;
    logic [3:0]      bumpers;
    thr_pick  = '{4'd0, 4'd15, 4'd2, ThrW'($urandom_range(WINDOW)), ThrW'($urandom),
                  4'd1, ThrW'(WINDOW - 1)};
    malf_pick = '{16'd0, 16'hFFFF, 16'd1, CntW'($urandom_range(12, 2)), MalfLimitRst,
                  CntW'($urandom_range(30, 3)), CntW'($urandom)};
    for (int unsigned p = 0; p < RandomPhases; p++) begin
      // keep one phase free of any idling
      idle_on = (p != 3);
      write_reg(CfgThreshold, (DataW'($urandom) & ~DataW'(16'hF)) | DataW'(thr_pick[p]));
      write_reg(CfgMalfLimit, malf_pick[p]);
      write_reg(CfgLeftDefect,
                (DataW'($urandom) & ~DataW'(1)) | DataW'($urandom_range(3) == 0));
      write_reg(CfgRightDefect,
                (DataW'($urandom) & ~DataW'(1)) | DataW'($urandom_range(3) == 0));
      churn = $urandom_range(40, 5);
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        for (int unsigned b = 0; b < 4; b++) begin
          if ($urandom_range(99) < churn) begin
            held_bumpers[b] = ~held_bumpers[b];
          end
        end
        bumpers  = ($urandom_range(9) == 0) ? 4'($urandom) : held_bumpers;
        gates    = ($urandom_range(99) < 85) ? GatesOpen : 3'($urandom);
        clock_ms = ($urandom_range(19) == 0) ? $urandom : clock_ms + $urandom_range(20, 1);
        send_frame(make_frame(bumpers, gates, clock_ms));
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_field_extremes();
    test_register_writes();
    test_defect_masking();
    test_threshold_above_window();
    test_random_frames();
    settle();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
